[src/arpc_pkg.sv]
package arpc_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [10:0] ARP_MIN_LEN    = 11'd28;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

  localparam logic OP_PACKET  = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  localparam logic [1:0] RK_REPLY = 2'd0;
  localparam logic [1:0] RK_HIT   = 2'd1;
  localparam logic [1:0] RK_MISS  = 2'd2;

  localparam logic [1:0] REG_OWN_IP      = 2'd0;
  localparam logic [1:0] REG_SUBNET_MASK = 2'd1;
  localparam logic [1:0] REG_GATEWAY_IP  = 2'd2;

  // one classified job for the table engine
  typedef struct packed {
    logic        learn;
    logic        reply;
    logic        lookup;
    logic [31:0] ip;
    logic [47:0] mac;
  } arpc_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_EXEC,
    BK_RESP
  } back_state_t;

endpackage

[src/arpc_front.sv]
module arpc_front
  import arpc_pkg::*;
(
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [10:0] arp_len,
  input  logic [15:0] arp_opcode,
  input  logic [31:0] src_ip,
  input  logic [47:0] src_mac,
  input  logic [31:0] dst_ip,
  input  logic [31:0] query_ip,
  input  logic [31:0] own_ip,
  input  logic [31:0] subnet_mask,
  input  logic [31:0] gateway_ip,
  input  logic        q_full,
  output logic        push,
  output arpc_cmd_t   cmd
);

  logic        accept;
  logic        pkt_ok;
  logic        off_subnet;
  logic [31:0] hop;

  assign busy   = q_full;
  assign accept = start && !q_full;

  assign pkt_ok     = (op == OP_PACKET) && (arp_len >= ARP_MIN_LEN);
  assign off_subnet = (subnet_mask != 32'd0) &&
                      ((query_ip & subnet_mask) != (own_ip & subnet_mask));
  assign hop        = off_subnet ? gateway_ip : query_ip;

  always_comb begin
    cmd.learn  = pkt_ok && (src_ip != 32'd0);
    cmd.reply  = pkt_ok && (arp_opcode == ARP_OP_REQUEST) &&
                 (dst_ip == own_ip) && (own_ip != 32'd0);
    cmd.lookup = (op == OP_RESOLVE);
    cmd.ip     = (op == OP_RESOLVE) ? hop : src_ip;
    cmd.mac    = src_mac;
  end

  // packets that neither teach nor answer are dropped here
  assign push = accept && (cmd.learn || cmd.reply || cmd.lookup);

endmodule

[src/arpc_queue.sv]
module arpc_queue
  import arpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  arpc_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output arpc_cmd_t pop_cmd,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  arpc_cmd_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/arpc_back.sv]
module arpc_back
  import arpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  output logic        pop,
  input  arpc_cmd_t   cmd,
  output logic        done,
  output logic [1:0]  result_kind,
  output logic [47:0] peer_mac,
  output logic [31:0] peer_ip
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  back_state_t state, state_next;

  arpc_cmd_t              cmd_q;
  logic [31:0]            entry_ip  [TABLE_ENTRIES];
  logic [47:0]            entry_mac [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0]       fifo_pointer;
  logic                   hit_found;
  logic [IDX_W-1:0]       hit_idx;
  logic [47:0]            rd_mac;

  logic [TABLE_ENTRIES-1:0] match;
  logic [IDX_W-1:0]       pick;
  logic                   learn_go;
  logic [IDX_W-1:0]       wr_addr;
  logic                   out_go;
  logic [1:0]             kind_next;
  logic [47:0]            mac_next;

  // parallel compare, lowest index wins
  always_comb begin
    pick = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      match[i] = entry_valid[i] && (entry_ip[i] == cmd_q.ip);
      if (match[i]) begin
        pick = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_go     = 1'b0;
    kind_next  = RK_REPLY;
    mac_next   = cmd_q.mac;
    unique case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        state_next = BK_EXEC;
      end
      BK_EXEC: begin
        out_go     = cmd_q.reply;
        state_next = cmd_q.lookup ? BK_RESP : BK_IDLE;
      end
      BK_RESP: begin
        out_go     = 1'b1;
        kind_next  = hit_found ? RK_HIT : RK_MISS;
        mac_next   = hit_found ? rd_mac : 48'd0;
        state_next = BK_IDLE;
      end
    endcase
  end

  assign learn_go = (state == BK_EXEC) && cmd_q.learn;
  assign wr_addr  = hit_found ? hit_idx : fifo_pointer;

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_q <= cmd;
    end
    if (state == BK_SEARCH) begin
      hit_found <= |match;
      hit_idx   <= pick;
    end
  end

  // MAC store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (learn_go) begin
      entry_mac[wr_addr] <= cmd_q.mac;
    end
    if (state == BK_EXEC) begin
      rd_mac <= entry_mac[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (learn_go && !hit_found) begin
      entry_ip[fifo_pointer] <= cmd_q.ip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      fifo_pointer <= '0;
    end else if (learn_go && !hit_found) begin
      entry_valid[fifo_pointer] <= 1'b1;
      fifo_pointer <= (fifo_pointer == IDX_W'(TABLE_ENTRIES - 1)) ?
                      '0 : fifo_pointer + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= out_go;
    end
  end

  always_ff @(posedge clk) begin
    if (out_go) begin
      result_kind <= kind_next;
      peer_mac    <= mac_next;
      peer_ip     <= cmd_q.ip;
    end
  end

endmodule

[src/arp_cache_responder.sv]
// ARP cache and request responder.
// Input: an item is transferred when start is high and busy is low. op 0
//   is a received ARP packet (learn sender, maybe answer a request for our
//   address), op 1 resolves an IPv4 address to a MAC via the cache.
// Output: each result is shown for exactly one cycle with done high; the
//   receiver cannot stall, so nothing ever backs up from the result side.
// Config: APB-style, own_ip at 0x0, subnet_mask at 0x4, gateway_ip at 0x8;
//   pready tied high, writes land on the access cycle.
// Sequence: the table engine takes each learn/reply job through pop,
//   compare over all entries and write, and each lookup through pop,
//   compare, MAC read and result; a reply or result leaves through the
//   registered done/result outputs.
//   A 2-deep job queue decouples intake from the engine, so short bursts
//   are taken at one per cycle and busy rises only when the queue is full.
// Reset (rst, synchronous): clears the valid marks, the replacement
//   pointer, the job queue and the config registers; no clearing pass.
module arp_cache_responder
  import arpc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [10:0] arp_len,
  input  logic [15:0] arp_opcode,
  input  logic [31:0] src_ip,
  input  logic [47:0] src_mac,
  input  logic [31:0] dst_ip,
  input  logic [31:0] query_ip,
  // result channel
  output logic        done,
  output logic [1:0]  result_kind,
  output logic [47:0] peer_mac,
  output logic [31:0] peer_ip,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] own_ip;
  logic [31:0] subnet_mask;
  logic [31:0] gateway_ip;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  arpc_cmd_t   push_cmd;
  arpc_cmd_t   pop_cmd;

  // ---- config registers ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip      <= '0;
      subnet_mask <= '0;
      gateway_ip  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_OWN_IP:      own_ip      <= pwdata;
        REG_SUBNET_MASK: subnet_mask <= pwdata;
        REG_GATEWAY_IP:  gateway_ip  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OWN_IP:      prdata = own_ip;
      REG_SUBNET_MASK: prdata = subnet_mask;
      REG_GATEWAY_IP:  prdata = gateway_ip;
      default:         prdata = '0;
    endcase
  end

  // ---- front: intake and classification (config sampled at transfer) ----
  arpc_front u_front (
    .start       (start),
    .busy        (busy),
    .op          (op),
    .arp_len     (arp_len),
    .arp_opcode  (arp_opcode),
    .src_ip      (src_ip),
    .src_mac     (src_mac),
    .dst_ip      (dst_ip),
    .query_ip    (query_ip),
    .own_ip      (own_ip),
    .subnet_mask (subnet_mask),
    .gateway_ip  (gateway_ip),
    .q_full      (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  // ---- job queue between intake and table engine ----
  arpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // ---- back: cache table, learning, lookups, result register ----
  arpc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .pop         (pop),
    .cmd         (pop_cmd),
    .done        (done),
    .result_kind (result_kind),
    .peer_mac    (peer_mac),
    .peer_ip     (peer_ip)
  );

endmodule

[src/arpc_checker.sv]
module arpc_checker
  import arpc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [1:0]  result_kind,
  input logic [47:0] peer_mac,
  input logic        pready
);

  // results are spaced out by the engine sequence
  a_done_gap: assert property (@(posedge clk) done |=> !done)
    else $error("back-to-back result strobes");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (result_kind == RK_REPLY || result_kind == RK_HIT ||
              result_kind == RK_MISS))
    else $error("undefined result kind");

  a_miss_mac: assert property (@(posedge clk) disable iff (rst)
    (done && result_kind == RK_MISS) |-> (peer_mac == 48'd0))
    else $error("miss carries a nonzero MAC");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind arp_cache_responder arpc_checker u_arpc_checker (
  .clk         (clk),
  .rst         (rst),
  .done        (done),
  .result_kind (result_kind),
  .peer_mac    (peer_mac),
  .pready      (pready)
);
